// ----- rtl/brf_pkg.sv -----
// Shared types, sizes and helper functions for the byte ring FIFO.
// Used by byte_ring_fifo_core and its testbench; depends on nothing else.
package brf_pkg;

  localparam int DEPTH = 256;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 9;
  localparam int DATA_W = 8;
  localparam int KIND_W = 3;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT_OVERWRITE = 3'd0,
    KIND_PUT_CHECKED   = 3'd1,
    KIND_GET           = 3'd2,
    KIND_REMOVE_NEWEST = 3'd3,
    KIND_FLUSH         = 3'd4
  } kind_t;

  function automatic logic [CNT_W-1:0] clamp_capacity(input logic [CAP_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] nx;
    nx = CNT_W'(idx) + CNT_W'(1);
    return (nx >= cap) ? '0 : IDX_W'(nx);
  endfunction

endpackage

// ----- rtl/brf_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the byte store of the ring FIFO.
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/byte_ring_fifo_core.sv -----
// Top level of the byte ring FIFO: index control, result register, store.
// Depends on brf_pkg and brf_ram.
//
// Input beats arrive on s_tvalid/s_tready with the operation kind on s_tuser
// and the byte to store on s_tdata. Each input beat yields exactly one result
// beat on m_tvalid/m_tready carrying the byte taken, the status, the count
// held afterward and the empty and full flags.
// The result of a beat appears in the cycle after it is accepted. A new beat is
// taken every cycle as long as the result register is free or is being
// emptied in the same cycle, so the sustained rate is one beat per clock;
// the indices and full flag update in the cycle of acceptance and the store
// read for a get completes in the following cycle through the registered
// RAM port. When the receiver stalls, the result is held and s_tready drops
// until it is taken.
// Synchronous reset empties the FIFO and sets the capacity to the full depth.
// Writing cfg_wdata with cfg_we set loads a new capacity (zero counts as one,
// values above the depth count as the depth) and also empties the FIFO; the
// store contents are never cleared.
module byte_ring_fifo_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [brf_pkg::IN_TDATA_W-1:0]  s_tdata,   // data_in[7:0]
  input  logic [brf_pkg::KIND_W-1:0]      s_tuser,   // kind[2:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // data_out[7:0], status[8], count[17:9], is_empty[18], is_full[19], zero pad
  output logic [brf_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [brf_pkg::CAP_W-1:0]       cfg_wdata
);

  import brf_pkg::*;

  logic [CNT_W-1:0]  capacity;
  logic [IDX_W-1:0]  write_index, write_index_next;
  logic [IDX_W-1:0]  read_index, read_index_next;
  logic              full_flag, full_flag_next;

  logic              out_take, out_status, out_empty, out_full;
  logic [CNT_W-1:0]  out_count;
  logic              take_next, status_next;
  logic [CNT_W-1:0]  count_next;

  logic              accept;
  logic              empty_now;
  logic              ram_we, ram_re;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] data_out;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign empty_now = !full_flag && (write_index == read_index);

  always_comb begin
    write_index_next = write_index;
    read_index_next  = read_index;
    full_flag_next   = full_flag;
    take_next        = 1'b0;
    status_next      = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    unique case (s_tuser)
      KIND_PUT_OVERWRITE, KIND_PUT_CHECKED: begin
        if (s_tuser == KIND_PUT_CHECKED && full_flag) begin
          status_next = 1'b1;
        end else begin
          ram_we           = 1'b1;
          read_index_next  = full_flag ? step_up(read_index, capacity) : read_index;
          write_index_next = step_up(write_index, capacity);
          full_flag_next   = (write_index_next == read_index_next);
        end
      end
      KIND_GET: begin
        if (empty_now) begin
          status_next = 1'b1;
        end else begin
          ram_re          = 1'b1;
          take_next       = 1'b1;
          read_index_next = step_up(read_index, capacity);
          full_flag_next  = 1'b0;
        end
      end
      KIND_REMOVE_NEWEST: begin
        if (empty_now) begin
          status_next = 1'b1;
        end else begin
          write_index_next = (write_index == '0) ? IDX_W'(capacity - CNT_W'(1))
                                                 : write_index - IDX_W'(1);
          full_flag_next   = 1'b0;
        end
      end
      KIND_FLUSH: begin
        write_index_next = '0;
        read_index_next  = '0;
        full_flag_next   = 1'b0;
      end
      default: begin
        status_next = 1'b1;
      end
    endcase
    if (!accept) begin
      ram_we = 1'b0;
      ram_re = 1'b0;
    end
  end

  always_comb begin
    if (full_flag_next) begin
      count_next = capacity;
    end else if (write_index_next >= read_index_next) begin
      count_next = CNT_W'(write_index_next) - CNT_W'(read_index_next);
    end else begin
      count_next = capacity + CNT_W'(write_index_next) - CNT_W'(read_index_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CNT_W'(DEPTH);
      write_index <= '0;
      read_index  <= '0;
      full_flag   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity    <= clamp_capacity(cfg_wdata);
        write_index <= '0;
        read_index  <= '0;
        full_flag   <= 1'b0;
      end else if (accept) begin
        write_index <= write_index_next;
        read_index  <= read_index_next;
        full_flag   <= full_flag_next;
      end
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_take   <= take_next;
      out_status <= status_next;
      out_count  <= count_next;
      out_empty  <= (count_next == '0);
      out_full   <= (count_next == capacity);
    end
  end

  brf_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(write_index),
    .wdata(s_tdata[DATA_W-1:0]),
    .re   (ram_re),
    .raddr(read_index),
    .rdata(ram_rdata)
  );

  assign data_out = out_take ? ram_rdata : '0;
  assign m_tdata  = OUT_TDATA_W'({out_full, out_empty, out_count, out_status, data_out});

  a_full_means_met: assert property (@(posedge clk) disable iff (rst)
    full_flag |-> (write_index == read_index))
    else $error("full flag set while indices differ");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (CNT_W'(write_index) < capacity) && (CNT_W'(read_index) < capacity))
    else $error("index at or beyond capacity");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_count <= capacity))
    else $error("result count exceeds capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted beat produced no result");

endmodule

// ----- sim/byte_ring_fifo_core_tb.sv -----
// Testbench for byte_ring_fifo_core: directed and random FIFO operations under several
// capacities, each result beat checked field by field against a ring model kept here.
// Depends on brf_pkg and the byte_ring_fifo_core RTL.
module byte_ring_fifo_core_tb;
  import brf_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
  localparam int MAX_IDLE  = 16;
  localparam int LONG_HOLD = 60;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] data;
    bit                after_drain;
  } fifo_op_t;

  typedef struct {
    logic [DATA_W-1:0] data_out;
    logic              status;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
    logic              is_full;
  } fifo_reply_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [KIND_W-1:0]      s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CAP_W-1:0]       cfg_wdata = '0;

  byte_ring_fifo_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  fifo_op_t    ops_to_send[$];
  fifo_reply_t replies_due[$];
  fifo_op_t    op_on_bus;

  logic [DATA_W-1:0] ring_mem [DEPTH];
  logic [IDX_W-1:0]  wr_ptr = '0;
  logic [IDX_W-1:0]  rd_ptr = '0;
  logic              ring_full = 1'b0;
  logic [CNT_W-1:0]  ring_cap = CNT_W'(DEPTH);

  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  int src_wait = 0;
  int sink_wait = 0;
  int hold_left = 0;
  int hold_at_reply = -1;
  int ops_accepted = 0;
  int replies_checked = 0;
  int settings_used = 0;
  int full_seen = 0;
  int refused_seen = 0;
  int errors = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("** byte_ring_fifo_core: FAILED **");
    $finish;
  end

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
    return (int'(p) + 1 >= int'(ring_cap)) ? '0 : p + IDX_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] ring_count();
    if (ring_full) begin
      return ring_cap;
    end
    if (wr_ptr >= rd_ptr) begin
      return CNT_W'(wr_ptr - rd_ptr);
    end
    return ring_cap + CNT_W'(wr_ptr) - CNT_W'(rd_ptr);
  endfunction

  task automatic ring_flush();
    wr_ptr = '0;
    rd_ptr = '0;
    ring_full = 1'b0;
  endtask

  task automatic ring_put(input logic [DATA_W-1:0] b);
    ring_mem[wr_ptr] = b;
    if (ring_full) begin
      rd_ptr = ring_next(rd_ptr);
    end
    wr_ptr = ring_next(wr_ptr);
    ring_full = (wr_ptr == rd_ptr);
  endtask

  task automatic predict_reply(input fifo_op_t op);
    fifo_reply_t r;
    logic        was_empty;
    r.data_out = '0;
    r.status = 1'b0;
    was_empty = !ring_full && (wr_ptr == rd_ptr);
    case (op.kind)
      KIND_PUT_OVERWRITE: begin
        ring_put(op.data);
      end
      KIND_PUT_CHECKED: begin
        if (ring_full) begin
          r.status = 1'b1;
        end else begin
          ring_put(op.data);
        end
      end
      KIND_GET: begin
        if (was_empty) begin
          r.status = 1'b1;
        end else begin
          r.data_out = ring_mem[rd_ptr];
          rd_ptr = ring_next(rd_ptr);
          ring_full = 1'b0;
        end
      end
      KIND_REMOVE_NEWEST: begin
        if (was_empty) begin
          r.status = 1'b1;
        end else begin
          wr_ptr = (wr_ptr == '0) ? IDX_W'(ring_cap - CNT_W'(1)) : wr_ptr - IDX_W'(1);
          ring_full = 1'b0;
        end
      end
      KIND_FLUSH: begin
        ring_flush();
      end
      default: begin
        r.status = 1'b1;
      end
    endcase
    r.count = ring_count();
    r.is_empty = (r.count == '0);
    r.is_full = (r.count == ring_cap);
    replies_due.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_reply(input logic [OUT_TDATA_W-1:0] beat);
    fifo_reply_t want;
    replies_checked++;
    if (replies_due.size() == 0) begin
      $display("%0t: result beat %h arrived with no operation outstanding", $time, beat);
      errors++;
      return;
    end
    want = replies_due.pop_front();
    check_field("data_out", CNT_W'(want.data_out), CNT_W'(beat[DATA_W-1:0]));
    check_field("status", CNT_W'(want.status), CNT_W'(beat[DATA_W]));
    check_field("count", want.count, beat[DATA_W+1 +: CNT_W]);
    check_field("is_empty", CNT_W'(want.is_empty), CNT_W'(beat[DATA_W+CNT_W+1]));
    check_field("is_full", CNT_W'(want.is_full), CNT_W'(beat[DATA_W+CNT_W+2]));
    full_seen += int'(want.is_full);
    refused_seen += int'(want.status);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_reply(op_on_bus);
        ops_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_wait > 0) begin
          src_wait--;
          s_tvalid <= 1'b0;
        end else if (ops_to_send.size() != 0 &&
                     !(ops_to_send[0].after_drain && replies_due.size() != 0)) begin
          op_on_bus = ops_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= op_on_bus.data;
          s_tuser <= op_on_bus.kind;
          src_wait = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_reply(m_tdata);
        sink_wait = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (replies_checked == hold_at_reply) begin
          hold_left = LONG_HOLD;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic queue_op(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] d,
                          input bit drain);
    fifo_op_t op;
    op.kind = k;
    op.data = d;
    op.after_drain = drain;
    ops_to_send.push_back(op);
  endtask

  function automatic logic [KIND_W-1:0] any_put();
    return $urandom_range(0, 1) ? KIND_PUT_CHECKED : KIND_PUT_OVERWRITE;
  endfunction

  // Puts outweigh gets so the ring keeps reaching full and wrapping.
  task automatic queue_traffic(input int n_ops);
    int left;
    int run;
    int pick;
    left = n_ops;
    while (left > 0) begin
      pick = $urandom_range(0, 15);
      run = $urandom_range(1, int'(ring_cap) + 2);
      if (run > left) begin
        run = left;
      end
      if (pick < 7) begin
        repeat (run) queue_op(any_put(), DATA_W'($urandom), $urandom_range(0, 39) == 0);
      end else if (pick < 12) begin
        repeat (run) queue_op(KIND_GET, DATA_W'($urandom), $urandom_range(0, 39) == 0);
      end else if (pick < 14) begin
        if (run > 3) begin
          run = 3;
        end
        repeat (run) queue_op(KIND_REMOVE_NEWEST, DATA_W'($urandom), 1'b0);
      end else if (pick == 14) begin
        run = 1;
        queue_op(KIND_FLUSH, DATA_W'($urandom), 1'b0);
      end else begin
        run = 1;
        queue_op(KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
                 DATA_W'($urandom), 1'b0);
      end
      left -= run;
    end
  endtask

  task automatic wait_idle();
    while (ops_to_send.size() != 0 || s_tvalid || replies_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (v == '0) begin
      ring_cap = CNT_W'(1);
    end else if (int'(v) > DEPTH) begin
      ring_cap = CNT_W'(DEPTH);
    end else begin
      ring_cap = CNT_W'(v);
    end
    ring_flush();
    settings_used++;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_ops, input bit fill_first,
                           input bit src_gaps, input bit sink_gaps, input int hold_after);
    wait_idle();
    write_capacity(cap);
    src_idle_on = src_gaps;
    sink_idle_on = sink_gaps;
    hold_at_reply = (hold_after > 0) ? replies_checked + hold_after : -1;
    if (fill_first) begin
      repeat (int'(ring_cap) + 2) queue_op(any_put(), DATA_W'($urandom), 1'b0);
    end
    queue_traffic(n_ops);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    queue_op(KIND_GET, 8'h11, 1'b0);
    queue_op(KIND_REMOVE_NEWEST, 8'h22, 1'b0);
    queue_op(KIND_PUT_OVERWRITE, 8'h00, 1'b0);
    queue_op(KIND_PUT_CHECKED, 8'hFF, 1'b0);
    queue_op(KIND_PUT_OVERWRITE, 8'hA5, 1'b0);
    queue_op(KIND_PUT_CHECKED, 8'h5A, 1'b0);
    queue_op(KIND_GET, 8'h00, 1'b0);
    queue_op(KIND_GET, 8'hFF, 1'b0);
    queue_op(KIND_REMOVE_NEWEST, 8'h00, 1'b0);
    queue_op(KIND_GET, 8'h00, 1'b0);
    queue_op(KIND_GET, 8'h00, 1'b0);
    queue_op(KIND_SPARE_FIRST, 8'hFF, 1'b0);
    queue_op(KIND_SPARE_FIRST + KIND_W'(1), 8'h00, 1'b0);
    queue_op(KIND_SPARE_LAST, 8'hFF, 1'b0);
    queue_op(KIND_PUT_OVERWRITE, 8'h3C, 1'b0);
    queue_op(KIND_FLUSH, 8'hFF, 1'b0);
    queue_op(KIND_GET, 8'h00, 1'b0);

    wait_idle();
    write_capacity('0);
    queue_op(KIND_PUT_CHECKED, 8'h81, 1'b0);
    queue_op(KIND_PUT_CHECKED, 8'h7E, 1'b0);
    queue_op(KIND_PUT_OVERWRITE, 8'h42, 1'b0);
    queue_op(KIND_GET, 8'h00, 1'b0);
    queue_op(KIND_REMOVE_NEWEST, 8'h00, 1'b0);
    queue_op(KIND_PUT_OVERWRITE, 8'h18, 1'b0);
    queue_op(KIND_REMOVE_NEWEST, 8'h00, 1'b0);
    queue_op(KIND_GET, 8'h00, 1'b0);

    run_phase(9'd2, 60, 1'b0, 1'b1, 1'b1, 0);
    run_phase(9'd511, 60, 1'b1, 1'b0, 1'b1, 0);
    run_phase(9'd3, 80, 1'b0, 1'b0, 1'b1, 20);
    run_phase(9'd17, 70, 1'b0, 1'b1, 1'b1, 0);
    queue_op(KIND_GET, DATA_W'($urandom), 1'b1);
    queue_traffic(20);
    run_phase(9'd256, 60, 1'b0, 1'b0, 1'b0, 30);
    run_phase(9'd255, 40, 1'b0, 1'b1, 1'b0, 0);
    run_phase(9'd1, 30, 1'b0, 1'b1, 1'b1, 0);
    run_phase(9'd300, 20, 1'b0, 1'b1, 1'b1, 0);

    wait_idle();
    repeat (4) @(posedge clk);
    $display("Ran %0d operations under %0d capacity settings, from one slot up to %0d.",
             ops_accepted, settings_used, DEPTH);
    $display("Results showed a full FIFO %0d times and %0d operations were refused.",
             full_seen, refused_seen);
    if (errors == 0) begin
      $display("** byte_ring_fifo_core: PASSED **");
    end else begin
      $display("** byte_ring_fifo_core: FAILED **");
    end
    $finish;
  end

endmodule
